// File: hw/rtl/zptw_pkg.sv
// zptw_pkg: shared types and constants of the z-order tile walker
// command and status structs between controller and datapath, register indexes
// no dependencies
`timescale 1ns / 1ps

package zptw_pkg;

  // stream widths, fields packed from bit 0 and filled to whole bytes
  localparam int IN_W  = 8;
  localparam int OUT_W = 72;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_COUNT = 2'd2;

  localparam logic [15:0] IMAGE_WIDTH_RST  = 16'd256;
  localparam logic [15:0] IMAGE_HEIGHT_RST = 16'd256;
  localparam logic [15:0] SAMPLE_COUNT_RST = 16'd128;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT
  } zptw_state_t;

  // controller to datapath
  typedef struct packed {
    logic load;   // latch grid size, start search at saved index
    logic step;   // move to the next morton index
    logic take;   // current tile is the result
    logic wrap;   // end of pass: advance sample range, restart at zero
    logic miss;   // no tile in whole grid: zero corner, reset index
    logic emit;   // load the output register
  } zptw_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic in_range;  // index below grid tile count
    logic tile_hit;  // tile corner inside the image
    logic wrapped;   // pass already advanced during this request
    logic out_free;  // output register can take a beat
  } zptw_sts_t;

endpackage

// File: hw/rtl/zptw_ctrl.sv
// zptw_ctrl: state machine that sequences one tile request
// depends on zptw_pkg
`timescale 1ns / 1ps

module zptw_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic                request,
  input  zptw_pkg::zptw_sts_t sts,
  output zptw_pkg::zptw_cmd_t cmd
);
  import zptw_pkg::*;

  zptw_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid && request) begin
          cmd.load  = 1'b1;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (!sts.in_range) begin
          if (!sts.wrapped) begin
            cmd.wrap = 1'b1;
          end else begin
            cmd.miss  = 1'b1;
            state_nxt = ST_EMIT;
          end
        end else if (sts.tile_hit) begin
          cmd.take  = 1'b1;
          state_nxt = ST_EMIT;
        end else begin
          cmd.step = 1'b1;
        end
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// File: hw/rtl/zptw_datapath.sv
// zptw_datapath: config registers, morton index counter, tile culling,
// sample range update and output register; depends on zptw_pkg
`timescale 1ns / 1ps

module zptw_datapath #(
  parameter int TILE_SIZE  = 8,
  parameter int INDEX_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [zptw_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [zptw_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  zptw_pkg::zptw_cmd_t              cmd,
  output zptw_pkg::zptw_sts_t              sts,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [zptw_pkg::OUT_W-1:0]       out_tdata
);
  import zptw_pkg::*;

  localparam int CB  = INDEX_BITS / 2;          // column / row bits
  localparam int GLW = $clog2(CB + 1);          // log2 of grid side, 0..CB
  localparam int SW  = CB + 7;                  // side or column times tile size
  localparam int CW  = (SW > 16) ? SW : 16;     // compare width

  logic [15:0] image_width_r, image_height_r, sample_count_r;
  logic [INDEX_BITS:0] idx_r, next_index_r;
  logic [15:0] range_first_r, range_last_r;
  logic [GLW-1:0] glog_r, glog_nxt;
  logic wrapped_r;
  logic [15:0] res_x_r, res_y_r;
  logic out_valid_r;
  logic [OUT_W-1:0] out_data_r;

  logic [CB-1:0] col, row;
  logic [CW-1:0] px, py;
  logic [16:0] dbl;
  logic [15:0] last_nxt;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r  <= IMAGE_WIDTH_RST;
      image_height_r <= IMAGE_HEIGHT_RST;
      sample_count_r <= SAMPLE_COUNT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_IMAGE_WIDTH:  image_width_r  <= cfg_data;
        CFG_IMAGE_HEIGHT: image_height_r <= cfg_data;
        CFG_SAMPLE_COUNT: sample_count_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // grid side: smallest power of two whose tile span passes both extents, capped
  always_comb begin
    glog_nxt = GLW'(CB);
    for (int k = CB - 1; k >= 0; k--) begin
      if (!(((CW'(TILE_SIZE) << k) <= CW'(image_width_r)) ||
            ((CW'(TILE_SIZE) << k) <= CW'(image_height_r)))) begin
        glog_nxt = GLW'(k);
      end
    end
  end

  // de-interleave: column on even bits, row on odd bits
  always_comb begin
    for (int b = 0; b < CB; b++) begin
      col[b] = idx_r[2*b];
      row[b] = idx_r[2*b+1];
    end
  end

  assign px = CW'(col) * CW'(TILE_SIZE);
  assign py = CW'(row) * CW'(TILE_SIZE);

  assign sts.in_range = ((idx_r >> {glog_r, 1'b0}) == '0);
  assign sts.tile_hit = (px < CW'(image_width_r)) && (py < CW'(image_height_r));
  assign sts.wrapped  = wrapped_r;
  assign sts.out_free = !out_valid_r || out_tready;

  // next pass range: last doubles, saturating at the sample count
  assign dbl      = {range_last_r, 1'b0};
  assign last_nxt = (dbl < {1'b0, sample_count_r}) ? dbl[15:0] : sample_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      next_index_r  <= '0;
      range_first_r <= '0;
      range_last_r  <= 16'd1;
      wrapped_r     <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cmd.load) begin
        wrapped_r <= 1'b0;
      end else if (cmd.wrap) begin
        wrapped_r     <= 1'b1;
        range_first_r <= range_last_r;
        range_last_r  <= last_nxt;
      end
      if (cmd.take) begin
        next_index_r <= idx_r + 1'b1;
      end else if (cmd.miss) begin
        next_index_r <= '0;
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      glog_r <= glog_nxt;
      idx_r  <= next_index_r;
    end else if (cmd.wrap) begin
      idx_r <= '0;
    end else if (cmd.step) begin
      idx_r <= idx_r + 1'b1;
    end
    if (cmd.take) begin
      res_x_r <= px[15:0];
      res_y_r <= py[15:0];
    end else if (cmd.miss) begin
      res_x_r <= '0;
      res_y_r <= '0;
    end
    if (cmd.emit) begin
      out_data_r <= {6'd0,
                     (range_first_r == range_last_r),
                     (range_first_r < range_last_r),
                     range_last_r, range_first_r, res_y_r, res_x_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // a found tile is only taken inside the grid and the image
  a_take_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.take |-> (sts.in_range && sts.tile_hit))
    else $error("tile taken outside grid or image");

  // output register never overwritten while a beat waits
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (!out_valid_r || out_tready))
    else $error("result overwrote a pending beat");

  // a pass advances at most once per request
  a_single_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.wrap && !cmd.load) |-> !wrapped_r)
    else $error("second pass advance in one request");

  // after a taken tile the search resumes past it
  a_take_index: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.take |=> (next_index_r != '0))
    else $error("next index did not move past taken tile");

endmodule

// File: hw/rtl/zorder_progressive_tile_walker_top.sv
// zorder_progressive_tile_walker_top: top level of the z-order tile walker
// instantiates zptw_ctrl and zptw_datapath; depends on zptw_pkg
`timescale 1ns / 1ps

// usage
// - in_* carries request beats; request = 1 asks for the next tile, a beat with
//   request = 0 is taken and dropped without a result
// - out_* returns one beat per request: tile corner in pixels and the sample
//   range of the current pass, with flags for a nonempty range and for done
// - cfg_* writes image width, height and sample count (indexes 0, 1, 2); write
//   only while no request is in flight
// - tiles are visited in morton order over a square power-of-two grid; tiles
//   whose corner lies outside the image are skipped one index per cycle
// - an accepted request scans from the saved index, restarts once at zero when
//   the pass wraps, and loads the output register once that register is free
// - the scan tests one morton index per cycle, which sets the rate if out_* is free
// - in_tready is high only while no request is being worked on; a finished
//   beat waiting in the output register does not hold off the next request,
//   but that request's result waits until the receiver takes the old one
// - reset (rst_n low at a clock edge) restores the register defaults
//   (256, 256, 128), restarts the walk at index 0 with range 0 to 1 and drops
//   any pending output beat
module zorder_progressive_tile_walker_top #(
  parameter int TILE_SIZE  = 8,
  parameter int INDEX_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // request beats
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [zptw_pkg::IN_W-1:0]       in_tdata,   // [0] request, [7:1] zero
  // result beats
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [15:0] tile_x, [31:16] tile_y, [47:32] sample_first, [63:48] sample_last,
  // [64] range_nonempty, [65] all_done, [71:66] zero
  output logic [zptw_pkg::OUT_W-1:0]      out_tdata,
  // register writes
  input  logic                            cfg_we,
  input  logic [zptw_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [zptw_pkg::CFG_DATA_W-1:0] cfg_data
);
  import zptw_pkg::*;

  zptw_cmd_t cmd;
  zptw_sts_t sts;

  // sequencer: accept, scan indexes, hand result to the output register
  zptw_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .request   (in_tdata[0]),
    .sts       (sts),
    .cmd       (cmd)
  );

  // index counter, culling, sample ranges and output beat register
  zptw_datapath #(
    .TILE_SIZE  (TILE_SIZE),
    .INDEX_BITS (INDEX_BITS)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .cmd        (cmd),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

// File: tb/sv/zorder_progressive_tile_walker_top_tb.sv
// zorder_progressive_tile_walker_top_tb: self-checking bench for the z-order tile walker
// predicts each tile beat from its own model of the morton walk and sample passes
// depends on zptw_pkg and zorder_progressive_tile_walker_top
`timescale 1ns / 1ps

module zorder_progressive_tile_walker_top_tb;
  import zptw_pkg::*;

  localparam int          TILE_SIZE     = 8;
  localparam int          INDEX_BITS    = 16;
  localparam int          RANDOM_TILES  = 1500;     // minimum tile requests in the random walks
  localparam int          TAIL_TILES    = 100;      // request beats with no idling at the end
  localparam int          HOLD_CYCLES   = 300;      // long receiver hold-off
  localparam longint      CYCLE_LIMIT   = 5000000;
  localparam int          MAX_PRINTS    = 40;

  // one expected result beat, laid out as on out_tdata
  typedef struct packed {
    logic        all_done;
    logic        nonempty;
    logic [15:0] smp_last;
    logic [15:0] smp_first;
    logic [15:0] tile_y;
    logic [15:0] tile_x;
  } tile_beat_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_W-1:0]       in_tdata;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_W-1:0]      out_tdata;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // walker model: registers, morton position and the current sample pass
  logic [15:0]  img_w;
  logic [15:0]  img_h;
  logic [15:0]  spp;
  int unsigned  walk_index;
  int unsigned  pass_first;
  int unsigned  pass_last;

  tile_beat_t   tile_queue[$];

  // bookkeeping
  int           error_count = 0;
  int           beats_seen = 0;
  int           tiles_requested = 0;
  int           ignored_beats = 0;
  int           pass_wraps = 0;
  int           empty_walks = 0;
  int           settings_used = 0;
  longint       cycle_count = 0;

  // idling controls: sender side used only by the stimulus process
  int           src_gap_pct = 0;
  int           sink_stall_pct = 0;
  int           hold_requests = 0;
  int           holds_served = 0;
  int           hold_left = 0;

  zorder_progressive_tile_walker_top #(
    .TILE_SIZE (TILE_SIZE),
    .INDEX_BITS(INDEX_BITS)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),    // [0] request, [7:1] zero
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    // [15:0] tile_x, [31:16] tile_y, [47:32] sample_first, [63:48] sample_last,
    // [64] range_nonempty, [65] all_done, [71:66] zero
    .out_tdata (out_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // ---------------------------------------------------------------------------
  // walker model
  // ---------------------------------------------------------------------------

  // gather the even bits of a morton code into a tile coordinate
  function automatic logic [15:0] even_gather(logic [31:0] code);
    logic [15:0] coord;
    for (int k = 0; k < 16; k++) begin
      coord[k] = code[2*k];
    end
    return coord;
  endfunction

  // tiles in the square grid: side covers both extents plus one, power of two, capped
  function automatic int unsigned grid_tiles();
    int unsigned cols;
    int unsigned rows;
    int unsigned span;
    int unsigned side;
    cols = img_w / TILE_SIZE + 1;
    rows = img_h / TILE_SIZE + 1;
    span = (cols > rows) ? cols : rows;
    side = 1;
    while (side < span && side < (32'd1 << (INDEX_BITS / 2))) begin
      side = side << 1;
    end
    return side * side;
  endfunction

  // corner compare uses the full product, no 16-bit truncation
  function automatic bit tile_inside(int unsigned idx);
    int unsigned px;
    int unsigned py;
    px = even_gather(idx) * TILE_SIZE;
    py = even_gather(idx >> 1) * TILE_SIZE;
    return (px < img_w) && (py < img_h);
  endfunction

  function automatic bit search_tile(int unsigned start, int unsigned count,
                                     output int unsigned hit);
    hit = 0;
    for (int unsigned i = start; i < count; i++) begin
      if (tile_inside(i)) begin
        hit = i;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // advance the walk by one request and return the beat it should produce
  function automatic tile_beat_t predict_next_tile();
    tile_beat_t  beat;
    int unsigned count;
    int unsigned hit;
    int unsigned doubled;
    bit          found;
    count = grid_tiles();
    found = search_tile(walk_index, count, hit);
    if (!found) begin
      // pass used up (or index beyond a shrunk grid): next pass, restart at zero
      doubled    = pass_last * 2;
      pass_first = pass_last;
      pass_last  = (doubled < spp) ? doubled : spp;
      pass_wraps++;
      found = search_tile(0, count, hit);
    end
    if (found) begin
      walk_index  = hit + 1;
      beat.tile_x = 16'(even_gather(hit) * TILE_SIZE);
      beat.tile_y = 16'(even_gather(hit >> 1) * TILE_SIZE);
    end else begin
      // nothing inside the image at all
      walk_index  = 0;
      beat.tile_x = '0;
      beat.tile_y = '0;
      empty_walks++;
    end
    beat.smp_first = pass_first[15:0];
    beat.smp_last  = pass_last[15:0];
    beat.nonempty  = pass_first < pass_last;
    beat.all_done  = pass_first == pass_last;
    return beat;
  endfunction

  // ---------------------------------------------------------------------------
  // checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    error_count++;
    if (error_count <= MAX_PRINTS) begin
      $display("[%0t] mismatch on %s at beat %0d: got 0x%0h, expected 0x%0h",
               $realtime, what, beats_seen, got, want);
    end
  endtask

  // every accepted result beat is compared with the oldest expected tile
  always @(posedge clk) begin : check_beats
    tile_beat_t want;
    if (rst_n === 1'b1 && out_tvalid === 1'b1 && out_tready === 1'b1) begin
      beats_seen++;
      if (tile_queue.size() == 0) begin
        report_mismatch("result beat with no request waiting", 1, 0);
      end else begin
        want = tile_queue.pop_front();
        if (out_tdata[15:0] !== want.tile_x)
          report_mismatch("tile_x", 32'(out_tdata[15:0]), 32'(want.tile_x));
        if (out_tdata[31:16] !== want.tile_y)
          report_mismatch("tile_y", 32'(out_tdata[31:16]), 32'(want.tile_y));
        if (out_tdata[47:32] !== want.smp_first)
          report_mismatch("sample_first", 32'(out_tdata[47:32]), 32'(want.smp_first));
        if (out_tdata[63:48] !== want.smp_last)
          report_mismatch("sample_last", 32'(out_tdata[63:48]), 32'(want.smp_last));
        if (out_tdata[64] !== want.nonempty)
          report_mismatch("range_nonempty", 32'(out_tdata[64]), 32'(want.nonempty));
        if (out_tdata[65] !== want.all_done)
          report_mismatch("all_done", 32'(out_tdata[65]), 32'(want.all_done));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // receiver: short random stalls, plus a long hold-off counted here
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    if (rst_n !== 1'b1) begin
      out_tready <= 1'b0;
    end else if (holds_served != hold_requests) begin
      holds_served <= hold_requests;
      hold_left    <= HOLD_CYCLES - 1;
      out_tready   <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else if ($urandom_range(1, 100) <= sink_stall_pct) begin
      // random stall burst, counted down in hold_left
      hold_left  <= $urandom_range(0, 7);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers, all entered and left at a rising edge
  // ---------------------------------------------------------------------------

  // offer one request beat; valid stays high afterwards so beats can go back to back
  task automatic send_request(bit req);
    int gap;
    if ($urandom_range(1, 100) <= src_gap_pct) begin
      gap = $urandom_range(1, 8);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_W-1){1'b0}}, req};
    do @(posedge clk); while (in_tready !== 1'b1);
    if (req) begin
      tiles_requested++;
      tile_queue.insert(tile_queue.size(), predict_next_tile());
    end else begin
      ignored_beats++;
    end
  endtask

  // stop offering and wait for every expected tile
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (tile_queue.size() != 0);
  endtask

  // a request-zero beat leaves no result, so also wait for in_tready before idling on
  task automatic wait_idle();
    wait_drained();
    while (in_tready !== 1'b1) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // write all three registers on consecutive edges, enable lowered once at the end
  task automatic apply_regs(logic [15:0] w, logic [15:0] h, logic [15:0] s);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_IMAGE_WIDTH;
    cfg_data  <= w;
    @(posedge clk);
    img_w = w;
    cfg_index <= CFG_IMAGE_HEIGHT;
    cfg_data  <= h;
    @(posedge clk);
    img_h = h;
    cfg_index <= CFG_SAMPLE_COUNT;
    cfg_data  <= s;
    @(posedge clk);
    spp = s;
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  task automatic send_burst(int n, int zero_pct);
    repeat (n) send_request($urandom_range(1, 100) > zero_pct);
  endtask

  // pick an image and sample count; sparse grids get only a few requests
  task automatic pick_setting(output logic [15:0] w, output logic [15:0] h,
                              output logic [15:0] s, output bit sparse);
    int kind;
    kind   = $urandom_range(0, 19);
    sparse = 1'b0;
    if (kind <= 6) begin
      // tiny grids wrap often, so sample ranges reach saturation
      w = 16'($urandom_range(1, 40));
      h = 16'($urandom_range(1, 40));
    end else if (kind <= 13) begin
      w = 16'($urandom_range(1, 400));
      h = 16'($urandom_range(1, 400));
    end else if (kind <= 16) begin
      // dense capped grid, every tile inside
      w = ($urandom_range(0, 2) == 0) ? 16'hFFFF : 16'($urandom_range(2048, 65535));
      h = ($urandom_range(0, 2) == 0) ? 16'hFFFF : 16'($urandom_range(2048, 65535));
    end else if (kind == 17) begin
      // a thin strip across the capped grid: long skips between tiles
      sparse = 1'b1;
      if ($urandom_range(0, 1) == 0) begin
        w = 16'($urandom_range(1, 16));
        h = 16'($urandom_range(40000, 65535));
      end else begin
        w = 16'($urandom_range(40000, 65535));
        h = 16'($urandom_range(1, 16));
      end
    end else begin
      w = 16'($urandom_range(1, 65535));
      h = 16'($urandom_range(1, 600));
    end
    case ($urandom_range(0, 5))
      0:       s = 16'd1;
      1:       s = 16'hFFFF;
      2:       s = 16'($urandom_range(1, 16));
      default: s = 16'($urandom_range(1, 65535));
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // reset registers, plain walk of a fully covered region, ignored beats around it
  task automatic test_default_walk();
    src_gap_pct = 20;
    send_request(1'b0);
    repeat (5) send_request(1'b1);
    send_request(1'b0);
  endtask

  // one tile per grid: every request ends a pass; small sample count reaches done
  // and stays there; the saved index lies beyond the new grid at the start
  task automatic test_pass_wrap();
    wait_idle();
    apply_regs(16'd8, 16'd8, 16'd4);
    repeat (7) send_request(1'b1);
  endtask

  // zero width, then zero height: no tile anywhere, corner reads as zero
  task automatic test_empty_image();
    wait_idle();
    apply_regs(16'd0, 16'd8, 16'd3);
    repeat (3) send_request(1'b1);
    wait_idle();
    apply_regs(16'd8, 16'd0, 16'd3);
    repeat (2) send_request(1'b1);
  endtask

  // grid side capped at the index width, then a one-pixel column of that grid
  task automatic test_grid_cap();
    wait_idle();
    apply_regs(16'hFFFF, 16'hFFFF, 16'hFFFF);
    repeat (3) send_request(1'b1);
    wait_idle();
    apply_regs(16'd1, 16'hFFFF, 16'd2);
    repeat (3) send_request(1'b1);
  endtask

  // receiver holds off long while requests keep coming, then the sender waits
  task automatic test_backpressure();
    wait_idle();
    apply_regs(16'd256, 16'd256, 16'($urandom_range(1, 65535)));
    src_gap_pct = 0;
    sink_stall_pct <= 0;
    hold_requests <= hold_requests + 1;
    repeat (12) send_request(1'b1);
    wait_drained();
    src_gap_pct = 10;
    sink_stall_pct <= 10;
    repeat (6) send_request(1'b1);
    wait_drained();
  endtask

  // random settings in phases, with varying idling on both sides
  task automatic test_random_walks();
    logic [15:0] w;
    logic [15:0] h;
    logic [15:0] s;
    bit          sparse;
    int          goal;
    goal = tiles_requested + RANDOM_TILES;
    while (tiles_requested < goal) begin
      wait_idle();
      pick_setting(w, h, s, sparse);
      apply_regs(w, h, s);
      case ($urandom_range(0, 3))
        0:       src_gap_pct = 0;
        1:       src_gap_pct = 50;
        default: src_gap_pct = 15;
      endcase
      case ($urandom_range(0, 3))
        0:       sink_stall_pct <= 0;
        1:       sink_stall_pct <= 40;
        default: sink_stall_pct <= 12;
      endcase
      send_burst(sparse ? $urandom_range(2, 8) : $urandom_range(10, 60), 12);
    end
  endtask

  // last stretch: no idling on either side
  task automatic test_quiet_tail();
    wait_idle();
    src_gap_pct = 0;
    sink_stall_pct <= 0;
    apply_regs(16'($urandom_range(1, 64)), 16'($urandom_range(1, 64)),
               16'($urandom_range(1, 65535)));
    send_burst(TAIL_TILES, 5);
  endtask

  // ---------------------------------------------------------------------------
  // run
  // ---------------------------------------------------------------------------

  initial begin
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    cfg_we     = 1'b0;
    cfg_index  = CFG_IMAGE_WIDTH;
    cfg_data   = '0;
    img_w      = IMAGE_WIDTH_RST;
    img_h      = IMAGE_HEIGHT_RST;
    spp        = SAMPLE_COUNT_RST;
    walk_index = 0;
    pass_first = 0;
    pass_last  = 1;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    sink_stall_pct <= 15;
    @(posedge clk);

    test_default_walk();
    test_pass_wrap();
    test_empty_image();
    test_grid_cap();
    test_backpressure();
    test_random_walks();
    test_quiet_tail();

    // drain, then linger so a stray extra beat would still be seen
    wait_drained();
    repeat (40) @(posedge clk);
    if (tile_queue.size() != 0)
      report_mismatch("tiles never returned", tile_queue.size(), 0);

    $display("walked %0d tile requests and %0d ignored beats over %0d register settings",
             tiles_requested, ignored_beats, settings_used);
    $display("%0d pass advances, %0d requests with no tile in the image, %0d cycles",
             pass_wraps, empty_walks, cycle_count);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // guard against a hung handshake
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("timeout after %0d cycles, %0d tiles still expected",
             cycle_count, tile_queue.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// File: files.f
hw/rtl/zptw_pkg.sv
hw/rtl/zptw_ctrl.sv
hw/rtl/zptw_datapath.sv
hw/rtl/zorder_progressive_tile_walker_top.sv
tb/sv/zorder_progressive_tile_walker_top_tb.sv
